>>> hdl/mpg_pkg.sv
// shared types, constants and step functions of the multilane random generator
package mpg_pkg;

  localparam int WORD_W    = 32;
  localparam int LANE_ID_W = 6;
  localparam int DIM_W     = 13;
  localparam int BC_W      = 18;
  localparam int PROD_W    = 25;
  localparam int FRAC_W    = 23;
  localparam int SH_W      = 5;

  localparam int unsigned XS_A       = 13;
  localparam int unsigned XS_B       = 17;
  localparam int unsigned XS_C       = 5;
  localparam int unsigned FRAC_SHIFT = 9;

  localparam logic [WORD_W-1:0] LFSR_MASK = 32'h8001_7BAE;
  localparam logic [WORD_W-1:0] ONE_EXP   = 32'h7F << 23;
  localparam logic [7:0]        EXP_TOP   = 8'd126;

  localparam logic [DIM_W-1:0]  DIM_MAX    = 13'd4096;
  localparam logic [DIM_W-1:0]  DIM_MIN    = 13'd1;
  localparam logic [DIM_W-1:0]  ROWS_RESET = 13'd64;
  localparam logic [DIM_W-1:0]  COLS_RESET = 13'd64;

  // input item function codes
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_GEN  = 1'b1;

  // generator and conversion selections
  localparam logic GEN_XORSHIFT = 1'b0;
  localparam logic CONV_UNIFORM = 1'b0;

  typedef enum logic [1:0] {
    REG_GEN_MODE,
    REG_CONV_MODE,
    REG_ROWS,
    REG_COLS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // one lane entering the shared unit
  typedef struct packed {
    logic                 valid;
    logic [LANE_ID_W-1:0] lane;
    logic                 last;
    logic                 mdone;
  } issue_t;

  // one converted lane leaving the shared unit
  typedef struct packed {
    logic                 valid;
    logic [WORD_W-1:0]    value;
    logic [LANE_ID_W-1:0] lane;
    logic                 last;
    logic                 mdone;
  } res_t;

  function automatic logic [WORD_W-1:0] step_xorshift(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = x ^ (x << XS_A);
    b = a ^ (a >> XS_B);
    return b ^ (b << XS_C);
  endfunction

  function automatic logic [WORD_W-1:0] step_lfsr(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] s;
    s = x >> 1;
    return x[0] ? (s ^ LFSR_MASK) : s;
  endfunction

  // left shift that brings the leading one of m to the top bit
  function automatic logic [SH_W-1:0] lead_shift(input logic [FRAC_W-1:0] m);
    logic [SH_W-1:0] p;
    p = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      if (m[i]) p = SH_W'(i);
    end
    return SH_W'(FRAC_W - 1) - p;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_MIN;
    else if (d > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

>>> hdl/mpg_if.sv
// valid/ready channel interfaces for input items and result beats
interface mpg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  lane;
  logic [31:0] seed;

  modport source (output valid, func, lane, seed, input ready);
  modport sink (input valid, func, lane, seed, output ready);
endinterface

interface mpg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [5:0]  out_lane;
  logic        last;
  logic        matrix_done;

  modport source (output valid, value, out_lane, last, matrix_done, input ready);
  modport sink (input valid, value, out_lane, last, matrix_done, output ready);
endinterface

>>> hdl/mpg_block_count.sv
// block counter and last-block detection for the rows x cols matrix
module mpg_block_count
  import mpg_pkg::*;
#(
  parameter int LANES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIM_W-1:0] rows,
  input  logic [DIM_W-1:0] cols,
  input  logic             step,
  output logic             done
);

  localparam int SC_W  = BC_W + 1 + $clog2(LANES + 1);
  localparam int CMP_W = (SC_W > PROD_W) ? SC_W : PROD_W;
  localparam logic [CMP_W-1:0] LANES_C = CMP_W'(LANES);
  localparam logic [CMP_W-1:0] SCALE_0 = CMP_W'(2 * LANES);

  logic [2*DIM_W-1:0]  product_full;
  logic [BC_W-1:0]     block_counter;
  // holds (block_counter + 2) * LANES
  logic [CMP_W-1:0]    scaled;

  // matrix size from the current registers
  assign product_full = clamp_dim(rows) * clamp_dim(cols);

  // last block when rows*cols < (counter + 2) * LANES
  assign done = CMP_W'(product_full) < scaled;

  // counter and its scaled copy
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      scaled        <= SCALE_0;
    end else if (step) begin
      if (done || (&block_counter)) begin
        block_counter <= '0;
        scaled        <= SCALE_0;
      end else begin
        block_counter <= block_counter + 1'b1;
        scaled        <= scaled + LANES_C;
      end
    end
  end

endmodule

>>> hdl/mpg_gen_unit.sv
// lane state memory with the shared step and float conversion pipeline
module mpg_gen_unit
  import mpg_pkg::*;
#(
  parameter int LANES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  issue_t            issue,
  input  logic              gen_mode,
  input  logic              conv_mode,
  input  logic              seed_we,
  input  logic [5:0]        seed_lane,
  input  logic [WORD_W-1:0] seed_data,
  output res_t              res,
  output logic              busy
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [WORD_W-1:0]    mem [LANES];
  logic [WORD_W-1:0]    rd_data;
  logic                 s1_valid;
  logic [LANE_ID_W-1:0] s1_lane;
  logic                 s1_last;
  logic                 s1_mdone;
  logic [WORD_W-1:0]    x_new;
  logic                 s2_valid;
  logic [LANE_ID_W-1:0] s2_lane;
  logic                 s2_last;
  logic                 s2_mdone;
  logic [WORD_W-1:0]    s2_x;
  logic [SH_W-1:0]      s2_sh;
  logic [FRAC_W-1:0]    m_new;
  logic [FRAC_W-1:0]    s2_m;
  logic [FRAC_W-1:0]    norm;
  logic [WORD_W-1:0]    uni;

  // lane state read, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= mem[issue.lane[LW-1:0]];
    end
  end

  // seed load or write-back of the stepped state
  always_ff @(posedge clk) begin
    if (seed_we) begin
      mem[seed_lane[LW-1:0]] <= seed_data;
    end else if (adv && s1_valid) begin
      mem[s1_lane[LW-1:0]] <= x_new;
    end
  end

  // first stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lane  <= issue.lane;
      s1_last  <= issue.last;
      s1_mdone <= issue.mdone;
    end
  end

  // generator step and leading-one search
  assign x_new = (gen_mode == GEN_XORSHIFT) ? step_xorshift(rd_data) : step_lfsr(rd_data);
  assign m_new = x_new[WORD_W-1:FRAC_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x     <= x_new;
      s2_m     <= m_new;
      s2_sh    <= lead_shift(m_new);
      s2_lane  <= s1_lane;
      s2_last  <= s1_last;
      s2_mdone <= s1_mdone;
    end
  end

  // normalise and pack the single float
  assign norm = s2_m << s2_sh;
  assign uni  = (s2_m == '0) ? {s2_x[0], 31'b0}
              : {s2_x[0], EXP_TOP - 8'(s2_sh), norm[FRAC_W-2:0], 1'b0};

  always_comb begin
    res.valid = s2_valid;
    res.value = (conv_mode == CONV_UNIFORM) ? uni : ({s2_x[0], 31'b0} | ONE_EXP);
    res.lane  = s2_lane;
    res.last  = s2_last;
    res.mdone = s2_mdone;
  end

  assign busy = s1_valid || s2_valid;

endmodule

>>> hdl/multilane_prng_matrix_generator.sv
// Multilane random matrix generator. A seed item (func 0) loads one lane's 32-bit state;
// a seed for a lane at or above LANES is dropped. A generate item (func 1) steps every
// lane once, by xorshift32 or a Galois LFSR, and delivers one float beat per lane in lane
// order, last set on the final lane and matrix_done on the final lane of the matrix's last
// block. Lanes are issued one per cycle, unless the output stalls, through the shared
// step and convert unit, which is fed by the single read port of the lane state memory.
// The input is not ready while a block is in flight. Lane states have no reset and must
// be seeded before the first generate item.
module multilane_prng_matrix_generator
  import mpg_pkg::*;
#(
  parameter int LANES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [DIM_W-1:0]   cfg_data,
  mpg_in_if.sink             in_ch,
  mpg_out_if.source          out_ch
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LW-1:0]        IDX_LAST  = LW'(LANES - 1);
  localparam logic [LANE_ID_W:0]   LANES_EXT = (LANE_ID_W + 1)'(LANES);

  state_t           state;
  state_t           state_next;
  logic             gen_mode;
  logic             conv_mode;
  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic [LW-1:0]    idx;
  logic             done_flag;
  logic             blk_done;
  logic             acc;
  logic             gen_acc;
  logic             seed_we;
  logic             adv;
  logic             busy;
  issue_t           issue;
  res_t             res;

  assign acc     = in_ch.valid && in_ch.ready;
  assign gen_acc = acc && (in_ch.func == FUNC_GEN);
  assign seed_we = acc && (in_ch.func == FUNC_SEED) && ({1'b0, in_ch.lane} < LANES_EXT);
  assign adv     = !out_ch.valid || out_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_mode  <= 1'b0;
      conv_mode <= 1'b0;
      rows      <= ROWS_RESET;
      cols      <= COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GEN_MODE:  gen_mode  <= cfg_data[0];
        REG_CONV_MODE: conv_mode <= cfg_data[0];
        REG_ROWS:      rows      <= cfg_data;
        REG_COLS:      cols      <= cfg_data;
        default: ;
      endcase
    end
  end

  mpg_block_count #(
    .LANES (LANES)
  ) u_count (
    .clk  (clk),
    .rst  (rst),
    .rows (rows),
    .cols (cols),
    .step (gen_acc),
    .done (blk_done)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (gen_acc) state_next = ST_ISSUE;
      ST_ISSUE: if (adv && (idx == IDX_LAST)) state_next = ST_DRAIN;
      ST_DRAIN: if (!busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    issue.valid = (state == ST_ISSUE);
    issue.lane  = LANE_ID_W'(idx);
    issue.last  = (idx == IDX_LAST);
    issue.mdone = done_flag && (idx == IDX_LAST);
  end

  // lane index and block end flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (gen_acc) begin
      idx <= '0;
    end else if ((state == ST_ISSUE) && adv && (idx != IDX_LAST)) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_acc) begin
      done_flag <= blk_done;
    end
  end

  mpg_gen_unit #(
    .LANES (LANES)
  ) u_gen (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .issue     (issue),
    .gen_mode  (gen_mode),
    .conv_mode (conv_mode),
    .seed_we   (seed_we),
    .seed_lane (in_ch.lane),
    .seed_data (in_ch.seed),
    .res       (res),
    .busy      (busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.value       <= res.value;
      out_ch.out_lane    <= res.lane;
      out_ch.last        <= res.last;
      out_ch.matrix_done <= res.mdone;
    end
  end

  // final beat of a block carries the top lane
  a_last_lane: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last |-> out_ch.out_lane == LANE_ID_W'(LANES - 1))
    else $error("last beat on wrong lane");

  // matrix end only on a block's final beat
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.matrix_done |-> out_ch.last)
    else $error("matrix_done without last");

  // no item taken while lanes are still in the pipeline
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    acc |-> !busy)
    else $error("item accepted while pipeline busy");

  // the stepping lane index advances only under an accepted slot
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) && !adv |=> $stable(idx))
    else $error("lane index moved during stall");

endmodule
